[hdl/ptts_pkg.sv]
// Shared types and constants for the periodic task tick scheduler.
package ptts_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int OP_W      = 2;
   localparam int HANDLER_W = 16;
   localparam int PERIOD_W  = 32;
   localparam int COUNT_W   = 64;
   localparam int KIND_W    = 3;
   localparam int SLOT_W    = 4;

   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_REGISTER = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DONE       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEARED    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HANDLER_W-1:0] handler;
      logic [PERIOD_W-1:0]  period;
      logic [COUNT_W-1:0]   due;
   } entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
      logic [COUNT_W-1:0]   tick_count;
      logic                 last;
   } result_type;

endpackage

[hdl/ptts_slot_mem.sv]
// Slot table memory: one write port, one read port, registered read data.
module ptts_slot_mem import ptts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [IW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ptts_ctrl.sv]
// Sequencer: tick counter, slot used bits, register/clear handling and slot walk.
module ptts_ctrl import ptts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [HANDLER_W-1:0] req_handler_id,
   input  logic [PERIOD_W-1:0]  req_interval,
   input  logic                 out_ready,
   output logic                 res_valid,
   output result_type           res,
   output logic                 mem_we,
   output logic [IW-1:0]        mem_waddr,
   output entry_type            mem_wdata,
   output logic [IW-1:0]        mem_raddr,
   input  entry_type            mem_rdata
);

   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
   localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SLOTS-1:0]     used_ff, used_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [HANDLER_W-1:0] handler_ff, handler_in;
   logic [PERIOD_W-1:0]  interval_ff, interval_in;

   logic                 accept;
   logic                 have_free;
   logic [IW-1:0]        free_idx;
   logic                 fire;
   logic                 advance;
   logic [IW-1:0]        idx_next;
   logic [PERIOD_W-1:0]  period_eff;

   function automatic logic [SLOT_W-1:0] slot_field(input logic [IW-1:0] i);
      logic [XW-1:0] ext;
      ext = XW'(i);
      return ext[SLOT_W-1:0];
   endfunction

   assign accept = req_valid && !req_stall;

   // lowest free slot
   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            have_free = 1'b1;
            free_idx  = IW'(i);
         end
      end
   end

   assign period_eff = (interval_ff == '0) ? PERIOD_W'(1) : interval_ff;
   assign fire       = used_ff[idx_ff] && (count_ff >= mem_rdata.due);
   assign advance    = !fire || out_ready;
   assign idx_next   = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      handler_in  = handler_ff;
      interval_in = interval_ff;
      req_stall   = (state_ff != ST_IDLE);
      res_valid   = 1'b0;
      res         = '{kind: KIND_REJECTED, slot: '0, handler: '0,
                      tick_count: count_ff, last: 1'b1};
      mem_we      = 1'b0;
      mem_waddr   = free_idx;
      mem_wdata   = '{handler: handler_ff, period: period_eff,
                      due: count_ff + COUNT_W'(period_eff)};
      mem_raddr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               handler_in  = req_handler_id;
               interval_in = req_interval;
               if (req_op == OP_TICK) begin
                  count_in = count_ff + 1'b1;
                  idx_in   = '0;
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_ONE;
               end
            end
         end
         ST_ONE: begin
            res_valid = 1'b1;
            case (op_ff)
               OP_REGISTER: begin
                  if (handler_ff != '0 && have_free) begin
                     res.kind    = KIND_REGISTERED;
                     res.slot    = slot_field(free_idx);
                     res.handler = handler_ff;
                     if (out_ready) begin
                        mem_we            = 1'b1;
                        used_in[free_idx] = 1'b1;
                     end
                  end
               end
               OP_CLEAR: begin
                  res.kind       = KIND_CLEARED;
                  res.tick_count = '0;
                  if (out_ready) begin
                     count_in = '0;
                     used_in  = '0;
                  end
               end
               default: ;
            endcase
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            // rd_data holds entry idx_ff; prefetch the next one when moving on
            mem_raddr = advance ? idx_next : idx_ff;
            if (fire) begin
               res_valid   = 1'b1;
               res.kind    = KIND_FIRED;
               res.slot    = slot_field(idx_ff);
               res.handler = mem_rdata.handler;
               res.last    = 1'b0;
            end
            mem_we    = fire && out_ready;
            mem_waddr = idx_ff;
            mem_wdata = '{handler: mem_rdata.handler, period: mem_rdata.period,
                          due: count_ff + COUNT_W'(mem_rdata.period)};
            if (advance) begin
               idx_in = idx_next;
               if (idx_ff == LAST) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            res.kind  = KIND_DONE;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      handler_ff  <= handler_in;
      interval_ff <= interval_in;
   end

   // a walk writes back only the entry whose fired transfer goes out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && mem_we) |-> (res_valid && out_ready && fire))
      else $error("walk write-back without fired transfer");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ONE && op_ff == OP_CLEAR && out_ready)
      |=> (used_ff == '0 && count_ff == '0))
      else $error("clear did not empty the table");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ONE && out_ready && res.kind == KIND_REGISTERED)
      |=> ($countones(used_ff) == $countones($past(used_ff)) + 1))
      else $error("register did not claim exactly one slot");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && advance && idx_ff != LAST)
      |=> (state_ff == ST_WALK && idx_ff == IW'($past(idx_ff) + 1'b1)))
      else $error("slot walk skipped an entry");

endmodule

[hdl/periodic_task_tick_scheduler_unit.sv]
// Register/clear/unknown op: result via ST_ONE and the output register.
// Tick: 1 result per due slot plus done; the walk reads one slot entry per cycle
// from the table memory, except while a fired result waits on an output stall.
// Items are taken one at a time; the next item is accepted once the last result
// is in the output register. Reset clears the counter and all slot used bits
// at once; the slot memory itself is not cleared.
module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [HANDLER_W-1:0] req_handler_id,
   input  logic [PERIOD_W-1:0]  req_interval,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [HANDLER_W-1:0] rsp_fired_handler,
   output logic [COUNT_W-1:0]   rsp_tick_count,
   output logic                 rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic          out_ready;
   logic          res_valid;
   result_type    res;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [IW-1:0] mem_raddr;
   entry_type     mem_rdata;

   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;

   ptts_ctrl #(.SLOTS(SLOTS), .IW(IW)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_handler_id (req_handler_id),
      .req_interval   (req_interval),
      .out_ready      (out_ready),
      .res_valid      (res_valid),
      .res            (res),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   ptts_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register: loads whenever it is empty or its transfer completes
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_ff.kind;
   assign rsp_slot          = rsp_ff.slot;
   assign rsp_fired_handler = rsp_ff.handler;
   assign rsp_tick_count    = rsp_ff.tick_count;
   assign rsp_last          = rsp_ff.last;

endmodule
